// ----- rtl/core/rssi_window_stats_dbm_assert.svh -----
// Assertion macros for the RSSI window statistics block.
// Every macro expects clk and rst_n in the scope where it is used.
`ifndef RSSI_WINDOW_STATS_DBM_ASSERT_SVH
`define RSSI_WINDOW_STATS_DBM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RWSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RWSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rwsd_pkg.sv -----
// Shared constants, types and state codes of the RSSI window statistics block.
// No dependencies; every other file of the block but the assertion header imports this package.
`timescale 1ns / 1ps

package rwsd_pkg;

    // Field widths.
    localparam int ADC_BITS  = 12;
    localparam int MV_BITS   = 12;
    localparam int CNT_W     = 8;
    localparam int DBM_W     = 16;
    localparam int OFFSET_W  = 14;
    localparam int RATIO_W   = 22;
    localparam int RATIO_FRAC = 16;

    // Stream and configuration widths.
    localparam int S_TDATA_W = ((ADC_BITS + MV_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((3 * ADC_BITS + DBM_W + 7) / 8) * 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = RATIO_W;

    // Digit-serial window accumulator.
    localparam int SUM_W       = 20;
    localparam int DIGIT_W     = 5;
    localparam int N_DIGITS    = SUM_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(N_DIGITS);

    // Shared bit-serial divider.
    localparam int DIV_N_W   = SUM_W + RATIO_FRAC;
    localparam int DIV_D_W   = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // Shared bit-serial multiplier.
    localparam int MUL_A_W   = 18;
    localparam int MUL_B_W   = RATIO_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_A_W + 1);

    // Level arithmetic.
    localparam int MV_W   = MUL_A_W;
    localparam int QMAG_W = 17;
    localparam int LVL_W  = 19;

    localparam logic [RATIO_W-1:0] RATIO_MAX      = '1;
    localparam logic [RATIO_W-1:0] RATIO_RESET    = 22'd52838;
    localparam logic [CNT_W-1:0]   RATIO_MIN_MEAN = 8'd200;

    localparam logic signed [DBM_W-1:0] LEVEL_FLOOR = -16'sd30720;
    localparam logic signed [DBM_W-1:0] LEVEL_CEIL  = 16'sd0;

    // Configuration reset values.
    localparam logic [CNT_W-1:0]           WINDOW_LEN_RESET  = 8'd16;
    localparam logic [MV_BITS-1:0]         CAL_MV_LOW_RESET  = 12'd500;
    localparam logic [MV_BITS-1:0]         CAL_MV_HIGH_RESET = 12'd1500;
    localparam logic signed [DBM_W-1:0]    CAL_DBM_LOW_RESET  = -16'sd23040;
    localparam logic signed [DBM_W-1:0]    CAL_DBM_HIGH_RESET = -16'sd7680;
    localparam logic signed [OFFSET_W-1:0] CAL_OFFSET_RESET   = 14'sd0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEN    = 3'd0,
        CFG_NOMINAL_RATIO = 3'd1,
        CFG_CAL_MV_LOW    = 3'd2,
        CFG_CAL_MV_HIGH   = 3'd3,
        CFG_CAL_DBM_LOW   = 3'd4,
        CFG_CAL_DBM_HIGH  = 3'd5,
        CFG_CAL_OFFSET    = 3'd6
    } cfg_index_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_RATIO_GO,
        S_RATIO_WAIT,
        S_MV_GO,
        S_MV_WAIT,
        S_NUM_GO,
        S_NUM_WAIT,
        S_LVL_GO,
        S_LVL_WAIT,
        S_OUT
    } seq_state_t;

    // Status of a shared serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // Control and status of the window accumulator.
    typedef struct packed {
        logic load;
        logic clear;
    } acc_ctl_t;

    typedef struct packed {
        logic busy;
        logic last;
        logic window_end;
    } acc_status_t;

endpackage

// ----- rtl/core/rwsd_accum.sv -----
// Digit-serial window accumulator: raw and mV sums, minimum, maximum, count.
// Depends on rwsd_pkg.
`timescale 1ns / 1ps

module rwsd_accum
    import rwsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  acc_ctl_t            ctl,
    input  logic [ADC_BITS-1:0] raw_sample,
    input  logic [MV_BITS-1:0]  mv_sample,
    input  logic [CNT_W-1:0]    window_len,
    output acc_status_t         status,
    output logic [SUM_W-1:0]    raw_sum,
    output logic [SUM_W-1:0]    mv_sum,
    output logic [ADC_BITS-1:0] low_seen,
    output logic [ADC_BITS-1:0] high_seen,
    output logic [CNT_W-1:0]    sample_count
);

    logic [SUM_W-1:0]       raw_sum_reg;
    logic [SUM_W-1:0]       mv_sum_reg;
    logic [SUM_W-1:0]       raw_op_reg;
    logic [SUM_W-1:0]       mv_op_reg;
    logic                   raw_carry_reg;
    logic                   mv_carry_reg;
    logic [DIGIT_CNT_W-1:0] digit_cnt_reg;
    logic [ADC_BITS-1:0]    low_reg;
    logic [ADC_BITS-1:0]    high_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   end_reg;

    logic [SUM_W-1:0]   raw_ext;
    logic [SUM_W-1:0]   mv_ext;
    logic               stepping;
    logic [DIGIT_W-1:0] raw_digit;
    logic [DIGIT_W-1:0] mv_digit;
    logic               raw_cin;
    logic               mv_cin;
    logic [DIGIT_W:0]   raw_dsum;
    logic [DIGIT_W:0]   mv_dsum;
    logic [SUM_W-1:0]   raw_op_shift;
    logic [SUM_W-1:0]   mv_op_shift;
    logic [CNT_W-1:0]   len_eff;
    logic [CNT_W-1:0]   count_inc;

    // One digit of each sum per cycle; the first digit is added as the sample arrives.
    always_comb
    begin
        raw_ext   = SUM_W'(raw_sample);
        mv_ext    = SUM_W'(mv_sample);
        stepping  = ctl.load || (digit_cnt_reg != '0);
        raw_digit = ctl.load ? raw_ext[DIGIT_W-1:0] : raw_op_reg[DIGIT_W-1:0];
        mv_digit  = ctl.load ? mv_ext[DIGIT_W-1:0] : mv_op_reg[DIGIT_W-1:0];
        raw_cin   = ctl.load ? 1'b0 : raw_carry_reg;
        mv_cin    = ctl.load ? 1'b0 : mv_carry_reg;
        raw_dsum  = {1'b0, raw_sum_reg[DIGIT_W-1:0]} + {1'b0, raw_digit}
                    + {{DIGIT_W{1'b0}}, raw_cin};
        mv_dsum   = {1'b0, mv_sum_reg[DIGIT_W-1:0]} + {1'b0, mv_digit}
                    + {{DIGIT_W{1'b0}}, mv_cin};
        raw_op_shift = (ctl.load ? raw_ext : raw_op_reg) >> DIGIT_W;
        mv_op_shift  = (ctl.load ? mv_ext : mv_op_reg) >> DIGIT_W;
        // A zero window length behaves as a window of one sample.
        len_eff   = (window_len == '0) ? CNT_W'(1) : window_len;
        count_inc = count_reg + 1'b1;
    end

    // Window state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_sum_reg   <= '0;
            mv_sum_reg    <= '0;
            raw_carry_reg <= 1'b0;
            mv_carry_reg  <= 1'b0;
            digit_cnt_reg <= '0;
            low_reg       <= '1;
            high_reg      <= '0;
            count_reg     <= '0;
            end_reg       <= 1'b0;
        end
        else if (ctl.clear)
        begin
            raw_sum_reg <= '0;
            mv_sum_reg  <= '0;
            low_reg     <= '1;
            high_reg    <= '0;
            count_reg   <= '0;
            end_reg     <= 1'b0;
        end
        else
        begin
            if (stepping)
            begin
                raw_sum_reg   <= {raw_dsum[DIGIT_W-1:0], raw_sum_reg[SUM_W-1:DIGIT_W]};
                mv_sum_reg    <= {mv_dsum[DIGIT_W-1:0], mv_sum_reg[SUM_W-1:DIGIT_W]};
                raw_carry_reg <= raw_dsum[DIGIT_W];
                mv_carry_reg  <= mv_dsum[DIGIT_W];
            end
            if (ctl.load)
            begin
                digit_cnt_reg <= DIGIT_CNT_W'(N_DIGITS - 1);
                if (raw_sample < low_reg)
                begin
                    low_reg <= raw_sample;
                end
                if (raw_sample > high_reg)
                begin
                    high_reg <= raw_sample;
                end
                count_reg <= count_inc;
                end_reg   <= (count_inc >= len_eff);
            end
            else if (digit_cnt_reg != '0)
            begin
                digit_cnt_reg <= digit_cnt_reg - 1'b1;
            end
        end
    end

    // Operand shift registers carry no state across samples.
    always_ff @(posedge clk)
    begin
        if (stepping)
        begin
            raw_op_reg <= raw_op_shift;
            mv_op_reg  <= mv_op_shift;
        end
    end

    assign status.busy       = (digit_cnt_reg != '0);
    assign status.last       = (digit_cnt_reg == DIGIT_CNT_W'(1));
    assign status.window_end = end_reg;
    assign raw_sum           = raw_sum_reg;
    assign mv_sum            = mv_sum_reg;
    assign low_seen          = low_reg;
    assign high_seen         = high_reg;
    assign sample_count      = count_reg;

endmodule

// ----- rtl/core/rwsd_serial_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
// Depends on rwsd_pkg.
`timescale 1ns / 1ps

module rwsd_serial_div
    import rwsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output unit_status_t       status,
    output logic [DIV_N_W-1:0] quotient
);

    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               fits;
    logic [DIV_D_W-1:0] rem_next;

    // Trial subtraction of the divisor from the partial remainder.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_N_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_N_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// ----- rtl/core/rwsd_serial_mul.sv -----
// Shift-and-add multiplier that consumes one multiplier bit per cycle.
// Depends on rwsd_pkg.
`timescale 1ns / 1ps

module rwsd_serial_mul
    import rwsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] mul_a,
    input  logic [MUL_B_W-1:0] mul_b,
    output unit_status_t       status,
    output logic [MUL_P_W-1:0] product
);

    logic [MUL_P_W-1:0]   prod_reg;
    logic [MUL_B_W-1:0]   mcand_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    logic [MUL_B_W:0]   upper;
    logic [MUL_P_W-1:0] prod_next;

    // Add the multiplicand when the current multiplier bit is set, then shift right.
    always_comb
    begin
        upper     = {1'b0, prod_reg[MUL_P_W-1:MUL_A_W]}
                    + {1'b0, mcand_reg & {MUL_B_W{prod_reg[0]}}};
        prod_next = {upper, prod_reg[MUL_A_W-1:1]};
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= MUL_CNT_W'(MUL_A_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == MUL_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Partial product and multiplier share one shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg  <= {{MUL_B_W{1'b0}}, mul_a};
            mcand_reg <= mul_b;
        end
        else if (cnt_reg != '0)
        begin
            prod_reg <= prod_next;
        end
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign product     = prod_reg;

endmodule

// ----- rtl/core/rssi_window_stats_dbm.sv -----
// Windowed RSSI statistics with a dBm level estimate. Within a window a sample's sums
// are built five bits a cycle in the window accumulator before the next sample is taken.
// The last sample of a window yields a result after up to three 36-step divisions and
// two 18-step products on the shared serial units.
// The next window starts once the result is in the output register; a stalled result blocks it.
// Reset (rst_n, asynchronous, active low) loads the register defaults and empties the window.
`timescale 1ns / 1ps

`include "rssi_window_stats_dbm_assert.svh"

module rssi_window_stats_dbm
    import rwsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // raw_sample, mv_sample
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // mean_count, min_raw, max_raw, level_dbm, zero fill
    output logic                  m_tuser,   // ratio_updated
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    seq_state_t state_reg;
    seq_state_t state_next;

    // Configuration registers and the running ratio.
    logic [CNT_W-1:0]           window_len_reg;
    logic [RATIO_W-1:0]         mv_per_count_reg;
    logic [MV_BITS-1:0]         cal_mv_low_reg;
    logic [MV_BITS-1:0]         cal_mv_high_reg;
    logic signed [DBM_W-1:0]    cal_dbm_low_reg;
    logic signed [DBM_W-1:0]    cal_dbm_high_reg;
    logic signed [OFFSET_W-1:0] cal_offset_reg;

    // Intermediate results of the end-of-window sequence.
    logic [ADC_BITS-1:0] mean_reg;
    logic                updated_reg;
    logic [MV_W-1:0]     mv_reg;
    logic                neg_reg;
    logic [QMAG_W-1:0]   qmag_reg;

    // Output register.
    logic [ADC_BITS-1:0]     out_mean_reg;
    logic [ADC_BITS-1:0]     out_min_reg;
    logic [ADC_BITS-1:0]     out_max_reg;
    logic signed [DBM_W-1:0] out_level_reg;
    logic                    out_updated_reg;
    logic                    m_tvalid_reg;

    // Unit connections.
    acc_ctl_t            acc_ctl;
    acc_status_t         acc_status;
    logic [SUM_W-1:0]    raw_sum;
    logic [SUM_W-1:0]    mv_sum;
    logic [ADC_BITS-1:0] low_seen;
    logic [ADC_BITS-1:0] high_seen;
    logic [CNT_W-1:0]    sample_count;

    logic               div_start;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    unit_status_t       div_status;
    logic [DIV_N_W-1:0] div_quot;

    logic               mul_start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    unit_status_t       mul_status;
    logic [MUL_P_W-1:0] mul_prod;

    logic out_free;
    logic out_load;
    logic cfg_write;

    // Datapath terms.
    logic [SUM_W-1:0]        ratio_thresh;
    logic                    ratio_due;
    logic [RATIO_W-1:0]      ratio_sat;
    logic signed [MV_W:0]    mv_diff;
    logic signed [MV_W:0]    mv_diff_neg;
    logic [MV_W-1:0]         mv_mag;
    logic signed [DBM_W:0]   dbm_diff;
    logic signed [DBM_W:0]   dbm_diff_neg;
    logic [DBM_W-1:0]        dbm_mag;
    logic signed [MV_BITS:0] den;
    logic signed [MV_BITS:0] den_neg;
    logic [MV_BITS-1:0]      den_mag;
    logic                    den_zero;
    logic [QMAG_W-1:0]       qmag_sat;
    logic signed [LVL_W-1:0] base_level;
    logic signed [LVL_W-1:0] q_pos;
    logic signed [LVL_W-1:0] q_signed;
    logic signed [LVL_W-1:0] level_sum;
    logic signed [DBM_W-1:0] level_clamped;

    rwsd_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (acc_ctl),
        .raw_sample   (s_tdata[ADC_BITS-1:0]),
        .mv_sample    (s_tdata[ADC_BITS+MV_BITS-1:ADC_BITS]),
        .window_len   (window_len_reg),
        .status       (acc_status),
        .raw_sum      (raw_sum),
        .mv_sum       (mv_sum),
        .low_seen     (low_seen),
        .high_seen    (high_seen),
        .sample_count (sample_count)
    );

    rwsd_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quot)
    );

    rwsd_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .status  (mul_status),
        .product (mul_prod)
    );

    // Arithmetic around the shared units: ratio test, sign and magnitude, level.
    always_comb
    begin
        ratio_thresh = SUM_W'(sample_count) * SUM_W'(RATIO_MIN_MEAN);
        ratio_due    = (raw_sum > ratio_thresh);
        ratio_sat    = (div_quot[DIV_N_W-1:RATIO_W] != '0) ? RATIO_MAX
                                                          : div_quot[RATIO_W-1:0];

        mv_diff      = $signed({1'b0, mv_reg}) - $signed((MV_W + 1)'(cal_mv_low_reg));
        mv_diff_neg  = -mv_diff;
        mv_mag       = mv_diff[MV_W] ? mv_diff_neg[MV_W-1:0] : mv_diff[MV_W-1:0];

        dbm_diff     = (DBM_W + 1)'(cal_dbm_high_reg) - (DBM_W + 1)'(cal_dbm_low_reg);
        dbm_diff_neg = -dbm_diff;
        dbm_mag      = dbm_diff[DBM_W] ? dbm_diff_neg[DBM_W-1:0] : dbm_diff[DBM_W-1:0];

        den          = $signed({1'b0, cal_mv_high_reg}) - $signed({1'b0, cal_mv_low_reg});
        den_neg      = -den;
        den_mag      = den[MV_BITS] ? den_neg[MV_BITS-1:0] : den[MV_BITS-1:0];
        den_zero     = (den == '0);

        // Quotients beyond the saturated magnitude clamp the level either way.
        qmag_sat     = (div_quot[DIV_N_W-1:QMAG_W] != '0) ? '1 : div_quot[QMAG_W-1:0];

        base_level   = LVL_W'(cal_dbm_low_reg) + LVL_W'(cal_offset_reg);
        q_pos        = $signed(LVL_W'(qmag_reg));
        q_signed     = neg_reg ? -q_pos : q_pos;
        level_sum    = base_level + q_signed;
        if (level_sum < LEVEL_FLOOR)
        begin
            level_clamped = LEVEL_FLOOR;
        end
        else if (level_sum > LEVEL_CEIL)
        begin
            level_clamped = LEVEL_CEIL;
        end
        else
        begin
            level_clamped = level_sum[DBM_W-1:0];
        end
    end

    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (acc_status.last)
                begin
                    state_next = acc_status.window_end ? S_MEAN_GO : S_IDLE;
                end
            end
            S_MEAN_GO:
            begin
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = ratio_due ? S_RATIO_GO : S_MV_GO;
                end
            end
            S_RATIO_GO:
            begin
                state_next = S_RATIO_WAIT;
            end
            S_RATIO_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = S_MV_GO;
                end
            end
            S_MV_GO:
            begin
                state_next = S_MV_WAIT;
            end
            S_MV_WAIT:
            begin
                if (mul_status.done)
                begin
                    state_next = den_zero ? S_OUT : S_NUM_GO;
                end
            end
            S_NUM_GO:
            begin
                state_next = S_NUM_WAIT;
            end
            S_NUM_WAIT:
            begin
                if (mul_status.done)
                begin
                    state_next = S_LVL_GO;
                end
            end
            S_LVL_GO:
            begin
                state_next = S_LVL_WAIT;
            end
            S_LVL_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer: unit starts, operand selection and handshakes.
    always_comb
    begin
        s_tready      = 1'b0;
        acc_ctl.load  = 1'b0;
        acc_ctl.clear = 1'b0;
        div_start     = 1'b0;
        div_dividend  = '0;
        div_divisor   = '0;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        out_load      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready     = 1'b1;
                acc_ctl.load = s_tvalid;
            end
            S_MEAN_GO:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_N_W'(raw_sum);
                div_divisor  = DIV_D_W'(sample_count);
            end
            S_RATIO_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {mv_sum, {RATIO_FRAC{1'b0}}};
                div_divisor  = raw_sum;
            end
            S_MV_GO:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(mean_reg);
                mul_b     = mv_per_count_reg;
            end
            S_NUM_GO:
            begin
                mul_start = 1'b1;
                mul_a     = mv_mag;
                mul_b     = MUL_B_W'(dbm_mag);
            end
            S_LVL_GO:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_N_W'(mul_prod);
                div_divisor  = DIV_D_W'(den_mag);
            end
            S_OUT:
            begin
                out_load      = out_free;
                acc_ctl.clear = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control state, configuration and the stored ratio.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            m_tvalid_reg     <= 1'b0;
            window_len_reg   <= WINDOW_LEN_RESET;
            mv_per_count_reg <= RATIO_RESET;
            cal_mv_low_reg   <= CAL_MV_LOW_RESET;
            cal_mv_high_reg  <= CAL_MV_HIGH_RESET;
            cal_dbm_low_reg  <= CAL_DBM_LOW_RESET;
            cal_dbm_high_reg <= CAL_DBM_HIGH_RESET;
            cal_offset_reg   <= CAL_OFFSET_RESET;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_WINDOW_LEN:    window_len_reg   <= cfg_data[CNT_W-1:0];
                    CFG_NOMINAL_RATIO: mv_per_count_reg <= cfg_data[RATIO_W-1:0];
                    CFG_CAL_MV_LOW:    cal_mv_low_reg   <= cfg_data[MV_BITS-1:0];
                    CFG_CAL_MV_HIGH:   cal_mv_high_reg  <= cfg_data[MV_BITS-1:0];
                    CFG_CAL_DBM_LOW:   cal_dbm_low_reg  <= $signed(cfg_data[DBM_W-1:0]);
                    CFG_CAL_DBM_HIGH:  cal_dbm_high_reg <= $signed(cfg_data[DBM_W-1:0]);
                    CFG_CAL_OFFSET:    cal_offset_reg   <= $signed(cfg_data[OFFSET_W-1:0]);
                    default:           window_len_reg   <= window_len_reg;
                endcase
            end
            else if ((state_reg == S_RATIO_WAIT) && div_status.done)
            begin
                mv_per_count_reg <= ratio_sat;
            end
        end
    end

    // Intermediate and output payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MEAN_GO)
        begin
            updated_reg <= 1'b0;
        end
        if ((state_reg == S_MEAN_WAIT) && div_status.done)
        begin
            mean_reg <= div_quot[ADC_BITS-1:0];
        end
        if ((state_reg == S_RATIO_WAIT) && div_status.done)
        begin
            updated_reg <= 1'b1;
        end
        if ((state_reg == S_MV_WAIT) && mul_status.done)
        begin
            mv_reg   <= mul_prod[RATIO_FRAC +: MV_W];
            // Equal calibration points give a flat line through the lower point.
            qmag_reg <= '0;
        end
        if (state_reg == S_NUM_GO)
        begin
            neg_reg <= mv_diff[MV_W] ^ dbm_diff[DBM_W] ^ den[MV_BITS];
        end
        if ((state_reg == S_LVL_WAIT) && div_status.done)
        begin
            qmag_reg <= qmag_sat;
        end
        if (out_load)
        begin
            out_mean_reg    <= mean_reg;
            out_min_reg     <= low_seen;
            out_max_reg     <= high_seen;
            out_level_reg   <= level_clamped;
            out_updated_reg <= updated_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({out_level_reg, out_max_reg, out_min_reg, out_mean_reg});
    assign m_tuser  = out_updated_reg;

    // Checks on the sequencer and the shared units.
    `RWSD_ASSERT_NOW(a_accept_acc_idle, s_tvalid && s_tready, !acc_status.busy, "sample taken while accumulator busy")
    `RWSD_ASSERT_NOW(a_div_start_idle, div_start, !div_status.busy, "divider restarted while busy")
    `RWSD_ASSERT_NOW(a_mul_start_idle, mul_start, !mul_status.busy, "multiplier restarted while busy")
    `RWSD_ASSERT_NOW(a_level_range, m_tvalid, (out_level_reg >= LEVEL_FLOOR) && (out_level_reg <= LEVEL_CEIL), "level outside clamp range")
    `RWSD_ASSERT_NEXT(a_ready_after_sample, (state_reg == S_ACC) && acc_status.last && !acc_status.window_end, s_tready, "not ready after a mid-window sample")

endmodule

// ----- tb/rssi_window_stats_dbm_tb.sv -----
// Self-checking testbench for the windowed RSSI statistics block with dBm level estimate.
// Depends on rwsd_pkg and the rssi_window_stats_dbm RTL; it predicts every window result
// itself and compares each result transaction field by field.
`timescale 1ns / 1ps

module rssi_window_stats_dbm_tb;
    import rwsd_pkg::*;

    localparam int     RANDOM_ITEMS = 1900;
    localparam int     DRAIN_CYCLES = 200;
    localparam int     HOLD_CYCLES  = 2000;
    localparam longint LIMIT_CYCLES = 10_000_000;

    // One input sample as it sits in s_tdata.
    typedef struct packed {
        logic [MV_BITS-1:0]  mv;
        logic [ADC_BITS-1:0] raw;
    } sample_t;

    // One predicted window result.
    typedef struct {
        logic [ADC_BITS-1:0]     mean;
        logic [ADC_BITS-1:0]     low;
        logic [ADC_BITS-1:0]     high;
        logic signed [DBM_W-1:0] level;
        logic                    refreshed;
    } window_result_t;

    // Shapes of random sample content.
    typedef enum int unsigned {
        MIX_UNIFORM,
        MIX_WEAK,
        MIX_TRACKING,
        MIX_STEADY
    } sample_mix_t;

    // Receiver back-pressure patterns.
    typedef enum int unsigned {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = CFG_WINDOW_LEN;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predicted configuration.
    logic [CNT_W-1:0]           win_len;
    logic [MV_BITS-1:0]         mv_lo;
    logic [MV_BITS-1:0]         mv_hi;
    logic signed [DBM_W-1:0]    dbm_lo;
    logic signed [DBM_W-1:0]    dbm_hi;
    logic signed [OFFSET_W-1:0] dbm_ofs;

    // Predicted window state.
    logic [SUM_W-1:0]    acc_raw;
    logic [SUM_W-1:0]    acc_mv;
    logic [ADC_BITS-1:0] seen_min;
    logic [ADC_BITS-1:0] seen_max;
    logic [CNT_W-1:0]    seen_cnt;
    logic [RATIO_W-1:0]  ratio_q16;

    sample_t        sample_queue[$];
    window_result_t window_results_due[$];

    int          fail_count   = 0;
    longint      cycle_count  = 0;
    bit          sample_fire  = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned gap_left     = 0;
    int unsigned burst_left   = 0;
    int unsigned hold_left    = 0;
    int unsigned mode_left    = 0;
    ready_mode_t ready_mode   = READY_ALWAYS;

    rssi_window_stats_dbm i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Empty the window accumulators.
    function automatic void clear_window();
        acc_raw  = '0;
        acc_mv   = '0;
        seen_min = '1;
        seen_max = '0;
        seen_cnt = '0;
    endfunction

    // Convert a mean raw count into a clamped Q8.8 dBm level.
    function automatic logic signed [DBM_W-1:0] level_of_mean(logic [ADC_BITS-1:0] mean);
        longint mv_est;
        longint span_mv;
        longint lvl;
        mv_est  = (longint'(mean) * longint'(ratio_q16)) >>> RATIO_FRAC;
        span_mv = longint'(mv_hi) - longint'(mv_lo);
        lvl     = longint'(dbm_lo) + longint'(dbm_ofs);
        // Equal calibration points give a flat line; division truncates toward zero.
        if (span_mv != 0)
            lvl += ((mv_est - longint'(mv_lo)) * (longint'(dbm_hi) - longint'(dbm_lo)))
                   / span_mv;
        if (lvl < longint'(LEVEL_FLOOR))
            lvl = LEVEL_FLOOR;
        if (lvl > longint'(LEVEL_CEIL))
            lvl = LEVEL_CEIL;
        return DBM_W'(lvl);
    endfunction

    // Add one accepted sample to the window and queue a result when the window closes.
    function automatic void absorb_sample(sample_t s);
        logic [CNT_W-1:0] span;
        window_result_t   res;
        longint           quotient;
        span = (win_len == '0) ? CNT_W'(1) : win_len;
        acc_raw  += SUM_W'(s.raw);
        acc_mv   += SUM_W'(s.mv);
        if (s.raw < seen_min)
            seen_min = s.raw;
        if (s.raw > seen_max)
            seen_max = s.raw;
        seen_cnt += CNT_W'(1);
        // The window closes once the count reaches the length, even if it was lowered.
        if (seen_cnt < span)
            return;
        res.mean      = ADC_BITS'(acc_raw / seen_cnt);
        res.refreshed = 1'b0;
        // A strong enough window refreshes the mV per count ratio before the level.
        if (longint'(acc_raw) > longint'(RATIO_MIN_MEAN) * longint'(seen_cnt))
        begin
            quotient      = (longint'(acc_mv) << RATIO_FRAC) / longint'(acc_raw);
            ratio_q16     = (quotient > longint'(RATIO_MAX)) ? RATIO_MAX : RATIO_W'(quotient);
            res.refreshed = 1'b1;
        end
        res.low   = seen_min;
        res.high  = seen_max;
        res.level = level_of_mean(res.mean);
        window_results_due.push_back(res);
        clear_window();
    endfunction

    // Mirror a configuration write into the predicted registers.
    function automatic void apply_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_WINDOW_LEN:    win_len   = value[CNT_W-1:0];
            CFG_NOMINAL_RATIO: ratio_q16 = value[RATIO_W-1:0];
            CFG_CAL_MV_LOW:    mv_lo     = value[MV_BITS-1:0];
            CFG_CAL_MV_HIGH:   mv_hi     = value[MV_BITS-1:0];
            CFG_CAL_DBM_LOW:   dbm_lo    = value[DBM_W-1:0];
            CFG_CAL_DBM_HIGH:  dbm_hi    = value[DBM_W-1:0];
            CFG_CAL_OFFSET:    dbm_ofs   = value[OFFSET_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] field_bits(int value, int width);
        return CFG_DATA_W'(value & ((1 << width) - 1));
    endfunction

    // Random register value, with the extremes and the odd corner weighted in.
    function automatic logic [CFG_DATA_W-1:0] pick_value(cfg_index_t idx);
        int unsigned roll;
        int          v;
        int          width;
        roll = $urandom_range(0, 9);
        case (idx)
            CFG_WINDOW_LEN:
            begin
                width = CNT_W;
                v = (roll == 0) ? 0 : (roll == 1) ? 255 : (roll < 4) ? 1 :
                    (roll == 4) ? $urandom_range(13, 64) : $urandom_range(2, 12);
            end
            CFG_NOMINAL_RATIO:
            begin
                width = RATIO_W;
                v = (roll == 0) ? 0 : (roll == 1) ? int'(RATIO_MAX) :
                    (roll == 2) ? $urandom_range(0, RATIO_MAX) : $urandom_range(20000, 120000);
            end
            CFG_CAL_MV_LOW:
            begin
                width = MV_BITS;
                v = (roll == 0) ? 0 : (roll == 1) ? 4095 : $urandom_range(100, 1500);
            end
            CFG_CAL_MV_HIGH:
            begin
                width = MV_BITS;
                v = (roll == 0) ? 0 : (roll == 1) ? 4095 : (roll == 2) ? int'(mv_lo) :
                    $urandom_range(800, 3500);
            end
            CFG_CAL_DBM_LOW, CFG_CAL_DBM_HIGH:
            begin
                width = DBM_W;
                v = (roll == 0) ? -30720 : (roll == 1) ? 0 :
                    (roll == 2) ? $urandom_range(0, 65535) : -int'($urandom_range(0, 30720));
            end
            CFG_CAL_OFFSET:
            begin
                width = OFFSET_W;
                v = (roll == 0) ? -5120 : (roll == 1) ? 5120 :
                    (roll == 2) ? $urandom_range(0, 16383) :
                    int'($urandom_range(0, 10240)) - 5120;
            end
            default:
            begin
                width = 1;
                v     = 0;
            end
        endcase
        return field_bits(v, width);
    endfunction

    // Random sample of the given shape.
    function automatic sample_t make_sample(sample_mix_t mix, int unsigned base,
                                            int unsigned slope);
        sample_t     s;
        int unsigned mv_est;
        case (mix)
            MIX_WEAK:
            begin
                s.raw = ADC_BITS'($urandom_range(0, 260));
                s.mv  = MV_BITS'($urandom_range(0, 4095));
            end
            MIX_TRACKING:
            begin
                s.raw  = ADC_BITS'($urandom);
                mv_est = ((int'(s.raw) * slope) >> 16) + $urandom_range(0, 7);
                s.mv   = (mv_est > 4095) ? '1 : MV_BITS'(mv_est);
            end
            MIX_STEADY:
            begin
                s.raw = ADC_BITS'(base ^ $urandom_range(0, 31));
                s.mv  = MV_BITS'(base ^ $urandom_range(0, 63));
            end
            default:
            begin
                s.raw = ADC_BITS'($urandom);
                s.mv  = MV_BITS'($urandom);
            end
        endcase
        return s;
    endfunction

    function automatic void offer(int raw, int mv);
        sample_queue.push_back(sample_t'{mv: MV_BITS'(mv), raw: ADC_BITS'(raw)});
    endfunction

    function automatic void check_field(string name, longint expected, longint actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            fail_count++;
        end
    endfunction

    // One configuration transaction; the predictor follows at the accepting edge.
    task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every sample is taken and every result has arrived, then let a
    // possibly unfinished window accumulation run out before the next write.
    task automatic settle();
        do
            @(posedge clk);
        while (sample_queue.size() != 0 || s_tvalid || window_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Cycle limit.
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sample sender: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin : sample_driver
        logic next_valid;
        next_valid = s_tvalid;
        if (sample_fire)
        begin
            sample_fire = 1'b0;
            next_valid  = 1'b0;
        end
        if (rst_n && !next_valid)
        begin
            if (gap_left != 0)
                gap_left--;
            else if (sample_queue.size() != 0)
            begin
                s_tdata    <= S_TDATA_W'(sample_queue.pop_front());
                next_valid = 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 32);
                    case ($urandom_range(0, 3))
                        1:       gap_left = $urandom_range(1, 4);
                        2:       gap_left = $urandom_range(5, 30);
                        default: gap_left = 0;
                    endcase
                end
            end
        end
        s_tvalid <= next_valid;
    end

    // Every accepted sample transaction goes through the predictor.
    always @(posedge clk)
    begin : sample_monitor
        if (rst_n && s_tvalid && s_tready)
        begin
            absorb_sample(sample_t'(s_tdata[ADC_BITS+MV_BITS-1:0]));
            sample_fire = 1'b1;
        end
    end

    // Result receiver: changing stall patterns, plus a long hold-off on request.
    always @(negedge clk)
    begin : result_receiver
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (mode_left != 0)
            mode_left--;
        else
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(40, 400);
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                READY_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
                default:      m_tready <= cycle_count[2];
            endcase
        end
    end

    // Compare each result transaction with the oldest predicted window result.
    always @(posedge clk)
    begin : result_monitor
        window_result_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (window_results_due.size() == 0)
            begin
                $error("result transaction with no window result pending");
                fail_count++;
            end
            else
            begin
                due = window_results_due.pop_front();
                check_field("mean_count", due.mean, m_tdata[ADC_BITS-1:0]);
                check_field("min_raw", due.low, m_tdata[2*ADC_BITS-1:ADC_BITS]);
                check_field("max_raw", due.high, m_tdata[3*ADC_BITS-1:2*ADC_BITS]);
                check_field("level_dbm", due.level,
                            $signed(m_tdata[3*ADC_BITS+DBM_W-1:3*ADC_BITS]));
                check_field("ratio_updated", due.refreshed, m_tuser);
            end
        end
    end

    initial
    begin : stimulus
        cfg_index_t  idx;
        sample_mix_t mix;
        int unsigned base;
        int unsigned slope;
        int unsigned span;
        int unsigned windows;
        int unsigned count;
        int unsigned rand_items;

        // Predicted state after reset.
        win_len   = WINDOW_LEN_RESET;
        ratio_q16 = RATIO_RESET;
        mv_lo     = CAL_MV_LOW_RESET;
        mv_hi     = CAL_MV_HIGH_RESET;
        dbm_lo    = CAL_DBM_LOW_RESET;
        dbm_hi    = CAL_DBM_HIGH_RESET;
        dbm_ofs   = CAL_OFFSET_RESET;
        clear_window();
        rand_items = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Single-sample windows: field extremes, the refresh threshold and ratio saturation.
        write_register(CFG_WINDOW_LEN, field_bits(1, CNT_W));
        offer(0, 0);
        offer(4095, 4095);
        offer(4095, 0);
        offer(0, 4095);
        offer(200, 100);
        offer(201, 300);
        offer(1, 4095);
        settle();

        // Zero window length and equal calibration points, level clamped at the ceiling.
        write_register(CFG_WINDOW_LEN, field_bits(0, CNT_W));
        write_register(CFG_CAL_MV_LOW, field_bits(1000, MV_BITS));
        write_register(CFG_CAL_MV_HIGH, field_bits(1000, MV_BITS));
        write_register(CFG_CAL_DBM_LOW, field_bits(0, DBM_W));
        write_register(CFG_CAL_OFFSET, field_bits(5120, OFFSET_W));
        offer(3000, 2000);
        offer(100, 50);
        settle();

        // Upper point below lower point, largest nominal ratio, weak window with no refresh.
        write_register(CFG_WINDOW_LEN, field_bits(4, CNT_W));
        write_register(CFG_CAL_MV_LOW, field_bits(4095, MV_BITS));
        write_register(CFG_CAL_MV_HIGH, field_bits(0, MV_BITS));
        write_register(CFG_CAL_DBM_LOW, field_bits(-30720, DBM_W));
        write_register(CFG_CAL_DBM_HIGH, field_bits(0, DBM_W));
        write_register(CFG_CAL_OFFSET, field_bits(-5120, OFFSET_W));
        write_register(CFG_NOMINAL_RATIO, field_bits(int'(RATIO_MAX), RATIO_W));
        offer(0, 4095);
        offer(200, 0);
        offer(150, 4095);
        offer(199, 17);
        settle();

        // Window length lowered part way through a window.
        write_register(CFG_WINDOW_LEN, field_bits(8, CNT_W));
        write_register(CFG_NOMINAL_RATIO, field_bits(0, RATIO_W));
        write_register(CFG_CAL_MV_LOW, field_bits(500, MV_BITS));
        write_register(CFG_CAL_MV_HIGH, field_bits(1500, MV_BITS));
        write_register(CFG_CAL_DBM_LOW, field_bits(-23040, DBM_W));
        write_register(CFG_CAL_DBM_HIGH, field_bits(-7680, DBM_W));
        write_register(CFG_CAL_OFFSET, field_bits(0, OFFSET_W));
        offer(10, 40);
        offer(300, 4095);
        offer(0, 0);
        offer(50, 9);
        offer(100, 100);
        settle();
        write_register(CFG_WINDOW_LEN, field_bits(2, CNT_W));
        offer(7, 3);
        settle();

        // Long receiver hold-off with one-sample windows so the block backs up.
        write_register(CFG_WINDOW_LEN, field_bits(1, CNT_W));
        @(posedge clk);
        hold_request = 1'b1;
        repeat (40) sample_queue.push_back(make_sample(MIX_UNIFORM, 0, 0));
        rand_items += 40;
        settle();

        // Random phases: writes while idle, then random windows, the last at times partial.
        while (rand_items < RANDOM_ITEMS)
        begin
            idx = idx.first();
            do
            begin
                if ($urandom_range(0, 2) == 0)
                    write_register(idx, pick_value(idx));
                idx = idx.next();
            end
            while (idx != idx.first());

            span    = (win_len == '0) ? 1 : win_len;
            windows = (span > 64) ? 1 : $urandom_range(1, 6);
            count   = span * windows;
            if (span > 1 && $urandom_range(0, 3) == 0)
                count += $urandom_range(1, span - 1);
            mix   = sample_mix_t'($urandom_range(0, 3));
            base  = $urandom_range(0, 4095);
            slope = $urandom_range(20000, 90000);
            repeat (count) sample_queue.push_back(make_sample(mix, base, slope));
            rand_items += count;
            settle();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
